// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the knot table block.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("assertion failed");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== rtl/pvit_pkg.sv =====
// Package of the piecewise volatility integral table: constants, payload
// structs, state enums and saturating helpers. No dependencies.
package pvit_pkg;

	localparam int MAX_KNOTS = 64;
	localparam int CNT_W = $clog2(MAX_KNOTS + 1);
	localparam int IDX_W = $clog2(MAX_KNOTS);

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_INTEG = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ORDER = 2'd2;

	localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] Q_HALF = 64'sh0000_8000_0000_0000;
	localparam logic [63:0] DIV_BIAS = 64'd6;
	localparam logic [4:0] DIV_BY = 5'd12;
	localparam logic [17:0] DIV3_MAGIC = 18'd174763;

	typedef struct packed {
		logic opcode;
		logic [31:0] knot_time;
		logic signed [31:0] knot_vol;
		logic signed [31:0] knot_slope;
		logic [31:0] from_time;
		logic [31:0] to_time;
	} pvit_in_t;

	typedef struct packed {
		logic signed [63:0] b_out;
		logic signed [63:0] var_s_out;
		logic signed [63:0] cov_out;
		logic signed [63:0] var_d_out;
		logic [1:0] status;
	} pvit_out_t;

	typedef struct packed {
		logic signed [63:0] b;
		logic signed [63:0] s;
		logic signed [63:0] c;
		logic signed [63:0] d;
	} pvit_res_t;

	typedef struct packed {
		logic [31:0] ktime;
		logic [31:0] g;
		logic [31:0] h;
		pvit_res_t cum;
	} pvit_knot_t;

	typedef struct packed {
		logic found;
		logic [31:0] t;
		pvit_knot_t knot;
	} pvit_end_t;

	typedef struct packed {
		pvit_end_t a;
		pvit_end_t z;
		logic ge;
	} pvit_tok_t;

	typedef enum logic [2:0] {
		T_IDLE, T_SCAN, T_EVAL, T_CALC, T_HOLD
	} pvit_top_state_t;

	typedef enum logic [2:0] {
		C_IDLE, C_BEGIN, C_ISSUE, C_WAIT, C_DIV, C_END, C_DONE
	} pvit_calc_state_t;

	typedef enum logic [3:0] {
		S_HDT, S_HALF, S_G2, S_W, S_SQ, S_WB, S_BB, S_WX, S_C1, S_AA, S_AAD, S_AC
	} pvit_step_t;

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			s = a[63] ? Q_MIN : Q_MAX;
		end
		return s;
	endfunction

	function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a - b;
		if (a[63] != b[63] && s[63] != a[63]) begin
			s = a[63] ? Q_MIN : Q_MAX;
		end
		return s;
	endfunction

	function automatic logic [63:0] magn(input logic signed [63:0] a);
		return a[63] ? (64'd0 - a) : a;
	endfunction

endpackage

// ===== rtl/pvit_cell.sv =====
// One knot cell of the table chain: holds a knot and updates the passing
// lookup token. Depends on pvit_pkg.
module pvit_cell (
	input  logic                  clk,
	input  logic                  en,
	input  logic                  valid,
	input  logic                  we,
	input  pvit_pkg::pvit_knot_t  wdata,
	input  pvit_pkg::pvit_tok_t   tin,
	output pvit_pkg::pvit_tok_t   tout
);

	pvit_pkg::pvit_knot_t knot_q;
	pvit_pkg::pvit_tok_t tok_q;
	pvit_pkg::pvit_tok_t tok_d;

	always_comb begin
		tok_d = tin;
		if (valid && knot_q.ktime < tin.a.t) begin
			tok_d.a.found = 1'b1;
			tok_d.a.knot = knot_q;
		end
		if (valid && knot_q.ktime < tin.z.t) begin
			tok_d.z.found = 1'b1;
			tok_d.z.knot = knot_q;
		end
		tok_d.ge = tin.ge | (valid && knot_q.ktime >= tin.a.t);
	end

	always_ff @(posedge clk) begin
		if (we) begin
			knot_q <= wdata;
		end
		if (en) begin
			tok_q <= tok_d;
		end
	end

	assign tout = tok_q;

endmodule

// ===== rtl/pvit_mul.sv =====
// Shared Q16.48 multiplier: four 32x32 partial products accumulated in turn,
// then rounding half away from zero and saturation. Depends on pvit_pkg.
module pvit_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [63:0]  a,
	input  logic signed [63:0]  b,
	output logic                done,
	output logic signed [63:0]  p
);

	logic busy_q;
	logic done_q;
	logic [2:0] cnt_q;
	logic [63:0] ua_q;
	logic [63:0] ub_q;
	logic neg_q;
	logic [127:0] acc_q;
	logic signed [63:0] p_q;
	logic [31:0] asel;
	logic [31:0] bsel;
	logic [63:0] pp;
	logic [127:0] pp_sh;
	logic [127:0] rsum;
	logic sat;
	logic [63:0] mag;
	logic signed [63:0] fin;

	always_comb begin
		asel = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
		bsel = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
		pp = asel * bsel;
		case (cnt_q[1:0])
			2'd0: pp_sh = {64'd0, pp};
			2'd3: pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
		rsum = acc_q + {80'd0, 1'b1, 47'd0};
		sat = (|rsum[127:111]) | rsum[111];
		mag = rsum[111:48];
		if (neg_q) begin
			fin = sat ? pvit_pkg::Q_MIN : -$signed(mag);
		end else begin
			fin = sat ? pvit_pkg::Q_MAX : $signed(mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 3'd0;
			end else if (busy_q) begin
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q <= pvit_pkg::magn(a);
			ub_q <= pvit_pkg::magn(b);
			neg_q <= a[63] ^ b[63];
			acc_q <= 128'd0;
		end else if (busy_q) begin
			if (cnt_q == 3'd4) begin
				p_q <= fin;
			end else begin
				acc_q <= acc_q + pp_sh;
			end
		end
	end

	assign done = done_q;
	assign p = p_q;

endmodule

// ===== rtl/pvit_calc.sv =====
// Sequencer for the closed-form extension of a knot and the interval terms,
// on one shared multiplier and a divide by twelve taken sixteen bits a cycle.
// Depends on pvit_pkg and pvit_mul.
module pvit_calc (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 op,
	input  pvit_pkg::pvit_tok_t  tok,
	output logic                 done,
	output pvit_pkg::pvit_res_t  res
);

	pvit_pkg::pvit_calc_state_t state_q, state_d;
	pvit_pkg::pvit_step_t step_q;
	logic end_q;
	logic [1:0] dcnt_q;
	logic [3:0] rem_q;
	logic [63:0] dn_q;
	logic signed [63:0] hdt_q, bm_q, g2_q, w_q, x_q, c_q, p_q, vd_q;
	pvit_pkg::pvit_res_t r_q, ra_q;

	pvit_pkg::pvit_end_t e;
	logic signed [63:0] dt, gw, hw, ds;
	logic signed [63:0] ma, mb, m;
	logic mul_start, mul_done;
	logic [19:0] dv;
	logic [35:0] dprod;
	logic [15:0] dq;
	logic [19:0] drem;

	pvit_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (ma),
		.b     (mb),
		.done  (mul_done),
		.p     (m)
	);

	always_comb begin
		e = end_q ? tok.z : tok.a;
		dt = $signed({8'd0, e.t - e.knot.ktime, 24'd0});
		gw = $signed({{12{e.knot.g[31]}}, e.knot.g, 20'd0});
		hw = $signed({{12{e.knot.h[31]}}, e.knot.h, 20'd0});
		ds = pvit_pkg::ssub(r_q.s, ra_q.s);
		// Sixteen quotient bits a cycle: divide by four, then by three with a reciprocal.
		dv = {rem_q, dn_q[63:48]};
		dprod = dv[19:2] * pvit_pkg::DIV3_MAGIC;
		dq = dprod[34:19];
		drem = dv - 20'(dq) * 20'(pvit_pkg::DIV_BY);
		case (step_q)
			pvit_pkg::S_HDT: begin ma = dt; mb = hw; end
			pvit_pkg::S_HALF: begin ma = pvit_pkg::Q_HALF; mb = hdt_q; end
			pvit_pkg::S_G2: begin ma = gw; mb = gw; end
			pvit_pkg::S_W: begin ma = g2_q; mb = dt; end
			pvit_pkg::S_SQ: begin ma = hdt_q; mb = hdt_q; end
			pvit_pkg::S_WB: begin ma = w_q; mb = bm_q; end
			pvit_pkg::S_BB: begin ma = bm_q; mb = bm_q; end
			pvit_pkg::S_WX: begin ma = w_q; mb = x_q; end
			pvit_pkg::S_C1: begin ma = ra_q.b; mb = ds; end
			pvit_pkg::S_AA: begin ma = ra_q.b; mb = ra_q.b; end
			pvit_pkg::S_AAD: begin ma = p_q; mb = ds; end
			default: begin ma = ra_q.b; mb = c_q; end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pvit_pkg::C_IDLE: begin
				if (start) state_d = pvit_pkg::C_BEGIN;
			end
			pvit_pkg::C_BEGIN: begin
				state_d = e.found ? pvit_pkg::C_ISSUE : pvit_pkg::C_END;
			end
			pvit_pkg::C_ISSUE: state_d = pvit_pkg::C_WAIT;
			pvit_pkg::C_WAIT: begin
				if (mul_done) begin
					case (step_q)
						pvit_pkg::S_SQ: state_d = pvit_pkg::C_DIV;
						pvit_pkg::S_WX: state_d = pvit_pkg::C_END;
						pvit_pkg::S_AC: state_d = pvit_pkg::C_DONE;
						default: state_d = pvit_pkg::C_ISSUE;
					endcase
				end
			end
			pvit_pkg::C_DIV: begin
				if (dcnt_q == 2'd3) state_d = pvit_pkg::C_ISSUE;
			end
			pvit_pkg::C_END: begin
				if (op == pvit_pkg::OP_APPEND) state_d = pvit_pkg::C_DONE;
				else if (!end_q) state_d = pvit_pkg::C_BEGIN;
				else state_d = pvit_pkg::C_ISSUE;
			end
			pvit_pkg::C_DONE: state_d = pvit_pkg::C_IDLE;
			default: state_d = pvit_pkg::C_IDLE;
		endcase
	end

	always_comb begin
		mul_start = state_q == pvit_pkg::C_ISSUE;
		done = state_q == pvit_pkg::C_DONE;
		if (op == pvit_pkg::OP_APPEND) begin
			res = ra_q;
		end else begin
			res.b = pvit_pkg::ssub(r_q.b, ra_q.b);
			res.s = ds;
			res.c = c_q;
			res.d = vd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pvit_pkg::C_IDLE;
			step_q <= pvit_pkg::S_HDT;
			end_q <= 1'b0;
			dcnt_q <= 2'd0;
		end else begin
			state_q <= state_d;
			case (state_q)
				pvit_pkg::C_IDLE: end_q <= 1'b0;
				pvit_pkg::C_BEGIN: step_q <= pvit_pkg::S_HDT;
				pvit_pkg::C_WAIT: begin
					if (mul_done) begin
						if (step_q == pvit_pkg::S_AC) step_q <= pvit_pkg::S_HDT;
						else step_q <= pvit_pkg::pvit_step_t'(step_q + 4'd1);
						dcnt_q <= 2'd0;
					end
				end
				pvit_pkg::C_DIV: dcnt_q <= dcnt_q + 2'd1;
				pvit_pkg::C_END: begin
					end_q <= 1'b1;
					step_q <= pvit_pkg::S_C1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pvit_pkg::C_BEGIN: begin
				if (!e.found) r_q <= '0;
			end
			pvit_pkg::C_WAIT: begin
				if (mul_done) begin
					case (step_q)
						pvit_pkg::S_HDT: begin
							hdt_q <= m;
							r_q.b <= pvit_pkg::sadd(e.knot.cum.b, m);
						end
						pvit_pkg::S_HALF: bm_q <= pvit_pkg::sadd(e.knot.cum.b, m);
						pvit_pkg::S_G2: g2_q <= m;
						pvit_pkg::S_W: begin
							w_q <= m;
							r_q.s <= pvit_pkg::sadd(e.knot.cum.s, m);
						end
						pvit_pkg::S_SQ: begin
							dn_q <= m + pvit_pkg::DIV_BIAS;
							rem_q <= 4'd0;
						end
						pvit_pkg::S_WB: r_q.c <= pvit_pkg::ssub(e.knot.cum.c, m);
						pvit_pkg::S_BB: x_q <= pvit_pkg::sadd(m, $signed(dn_q));
						pvit_pkg::S_WX: r_q.d <= pvit_pkg::sadd(e.knot.cum.d, m);
						pvit_pkg::S_C1: c_q <= pvit_pkg::ssub(pvit_pkg::ssub(r_q.c, ra_q.c), m);
						pvit_pkg::S_AA: p_q <= m;
						pvit_pkg::S_AAD: vd_q <= pvit_pkg::ssub(pvit_pkg::ssub(r_q.d, ra_q.d), m);
						default: vd_q <= pvit_pkg::ssub(vd_q, pvit_pkg::sadd(m, m));
					endcase
				end
			end
			pvit_pkg::C_DIV: begin
				rem_q <= drem[3:0];
				dn_q <= {dn_q[47:0], dq};
			end
			pvit_pkg::C_END: begin
				if (!end_q) ra_q <= r_q;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/piecewise_vol_integral_table.sv =====
// Top level of the piecewise volatility integral table: chain of knot cells,
// control sequencer and output register. Depends on pvit_pkg, pvit_cell,
// pvit_calc and assert_macros.svh.
//
// Input beats arrive on in_valid/in_ready with an in_data struct; results
// leave on out_valid/out_ready with an out_data struct, one result beat for
// every input beat, in order. Opcode append stores a knot at the end of the
// table; opcode integrate returns the four interval integrals.
// One beat is worked at a time. A lookup token walks the row of MAX_KNOTS
// cells, one cell a cycle, then the sequencer works the closed form on the
// shared multiplier and the divide by twelve; a rejected append skips it.
// The next beat can be taken in the cycle after the result is loaded.
// A finished result sits in the output register; the next input beat is
// taken while it waits, but a second result is held back until the receiver
// takes the first. Reset empties the table and drops any beat in flight.
`include "assert_macros.svh"

module piecewise_vol_integral_table (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pvit_pkg::pvit_in_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pvit_pkg::pvit_out_t  out_data
);

	pvit_pkg::pvit_top_state_t state_q, state_d;
	logic [pvit_pkg::CNT_W-1:0] count_q;
	logic [pvit_pkg::IDX_W-1:0] scan_q;
	logic [1:0] stat_q;
	logic out_valid_q;
	pvit_pkg::pvit_out_t out_q;
	pvit_pkg::pvit_in_t in_q;
	pvit_pkg::pvit_tok_t tok_q;

	pvit_pkg::pvit_tok_t tok_w [pvit_pkg::MAX_KNOTS+1];
	pvit_pkg::pvit_tok_t tail;
	pvit_pkg::pvit_tok_t tok_init;
	pvit_pkg::pvit_knot_t wdata;
	pvit_pkg::pvit_res_t calc_res;
	logic calc_start, calc_done;
	logic scan_en, load, wr, accept, scan_last;
	logic [1:0] eval_stat;

	assign tok_w[0] = tok_q;
	assign tail = tok_w[pvit_pkg::MAX_KNOTS];

	assign wdata.ktime = in_q.knot_time;
	assign wdata.g = in_q.knot_vol;
	assign wdata.h = in_q.knot_slope;
	assign wdata.cum = calc_res;

	genvar gi;
	generate
		for (gi = 0; gi < pvit_pkg::MAX_KNOTS; gi++) begin : g_cell
			pvit_cell u_cell (
				.clk  (clk),
				.en   (scan_en),
				.valid(count_q > pvit_pkg::CNT_W'(gi)),
				.we   (wr && count_q == pvit_pkg::CNT_W'(gi)),
				.wdata(wdata),
				.tin  (tok_w[gi]),
				.tout (tok_w[gi+1])
			);
		end
	endgenerate

	pvit_calc u_calc (
		.clk   (clk),
		.arst_n(arst_n),
		.start (calc_start),
		.op    (in_q.opcode),
		.tok   (tail),
		.done  (calc_done),
		.res   (calc_res)
	);

	always_comb begin
		accept = in_valid && in_ready;
		scan_last = scan_q == pvit_pkg::IDX_W'(pvit_pkg::MAX_KNOTS - 1);
		tok_init = '0;
		tok_init.a.t = (in_data.opcode == pvit_pkg::OP_APPEND) ?
			in_data.knot_time : in_data.from_time;
		tok_init.z.t = in_data.to_time;
		eval_stat = pvit_pkg::ST_OK;
		if (in_q.opcode == pvit_pkg::OP_APPEND) begin
			if (count_q == pvit_pkg::CNT_W'(pvit_pkg::MAX_KNOTS)) begin
				eval_stat = pvit_pkg::ST_FULL;
			end else if (count_q != '0 && tail.ge) begin
				eval_stat = pvit_pkg::ST_ORDER;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pvit_pkg::T_IDLE: if (accept) state_d = pvit_pkg::T_SCAN;
			pvit_pkg::T_SCAN: if (scan_last) state_d = pvit_pkg::T_EVAL;
			pvit_pkg::T_EVAL: begin
				state_d = (eval_stat == pvit_pkg::ST_OK) ? pvit_pkg::T_CALC : pvit_pkg::T_HOLD;
			end
			pvit_pkg::T_CALC: if (calc_done) state_d = pvit_pkg::T_HOLD;
			pvit_pkg::T_HOLD: if (!out_valid_q || out_ready) state_d = pvit_pkg::T_IDLE;
			default: state_d = pvit_pkg::T_IDLE;
		endcase
	end

	always_comb begin
		in_ready = state_q == pvit_pkg::T_IDLE;
		scan_en = state_q == pvit_pkg::T_SCAN;
		calc_start = state_q == pvit_pkg::T_EVAL && eval_stat == pvit_pkg::ST_OK;
		load = state_q == pvit_pkg::T_HOLD && (!out_valid_q || out_ready);
		wr = load && in_q.opcode == pvit_pkg::OP_APPEND && stat_q == pvit_pkg::ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pvit_pkg::T_IDLE;
			count_q <= '0;
			scan_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) scan_q <= '0;
			else if (scan_en) scan_q <= scan_q + 1'b1;
			if (wr) count_q <= count_q + 1'b1;
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= in_data;
			tok_q <= tok_init;
		end
		if (state_q == pvit_pkg::T_EVAL) stat_q <= eval_stat;
		if (load) begin
			out_q.status <= stat_q;
			if (in_q.opcode == pvit_pkg::OP_APPEND) begin
				out_q.b_out <= '0;
				out_q.var_s_out <= '0;
				out_q.cov_out <= '0;
				out_q.var_d_out <= '0;
			end else begin
				out_q.b_out <= calc_res.b;
				out_q.var_s_out <= calc_res.s;
				out_q.cov_out <= calc_res.c;
				out_q.var_d_out <= calc_res.d;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > pvit_pkg::CNT_W'(pvit_pkg::MAX_KNOTS))
	`ASSERT_AT(a_wr_room, clk, arst_n, wr |-> count_q != pvit_pkg::CNT_W'(pvit_pkg::MAX_KNOTS))
	`ASSERT_AT(a_done_in_calc, clk, arst_n, calc_done |-> state_q == pvit_pkg::T_CALC)
	`ASSERT_AT(a_load_frees, clk, arst_n, load |=> out_valid_q)

endmodule
